// ===== rtl/bpus_pkg.sv =====
`timescale 1ns / 1ps
// Package for the budgeted priority upload scheduler: types, codes and defaults.
// No dependencies; used by budgeted_priority_upload_scheduler.
package bpus_pkg;

    // Default sizing
    localparam int QUEUE_DEPTH_DEF      = 32;
    localparam int FRAMES_IN_FLIGHT_DEF = 2;

    // Register reset value
    localparam logic [31:0] BUDGET_RESET = 32'd4194304;

    // Stream payload widths (bits, zero padded)
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 64;

    // Input item kinds (tuser on the slave side)
    typedef enum logic [1:0] {
        KIND_SUBMIT  = 2'd0,
        KIND_BEGIN   = 2'd1,
        KIND_PROCESS = 2'd2
    } t_kind;

    // Result status codes (tuser on the master side)
    typedef enum logic [2:0] {
        ST_QUEUED  = 3'd0,
        ST_IGNORED = 3'd1,
        ST_FULL    = 3'd2,
        ST_BEGUN   = 3'd3,
        ST_GRANTED = 3'd4,
        ST_NONE    = 3'd5
    } t_status;

    // Queue entry as held in the RAM
    typedef struct packed {
        logic [15:0]        tag;
        logic [31:0]        size;
        logic signed [15:0] prio;
    } t_entry;

    // One result beat
    typedef struct packed {
        t_status     status;
        logic [15:0] tag;
        logic [7:0]  slot;
        logic [31:0] offset;
        logic [5:0]  pending;
        logic        last;
    } t_result;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_SCAN_RD,
        S_FIT_FRAME,
        S_FIT_SLOT,
        S_RESULT
    } t_state;

endpackage

// ===== rtl/bpus_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bpus_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/budgeted_priority_upload_scheduler.sv =====
`timescale 1ns / 1ps
// Top level of the budgeted priority upload scheduler.
// Depends on bpus_pkg and bpus_ram.

// Keeps up to QUEUE_DEPTH pending uploads in a RAM, always in stable ascending
// priority order (a submit is placed behind every entry of equal or lower
// priority value), so a process beat is a single front-to-back scan. Beats on
// the slave stream carry the kind in tuser; each beat gives one or more result
// beats on the master stream, the final one flagged with tlast (kind 3 gives
// none). A process beat emits one result per grant in scan order, or a single
// "none granted" result; unfitting uploads are compacted in place and kept.
// Timing is set by the one RAM port pair and the one shared 33-bit
// add/compare unit. A submit reads and shifts up each entry it moves past,
// starting from the back of the queue; a process beat takes each entry
// through read, budget check and slot check, and an entry failing the
// budget check skips the slot check. A master-side stall holds the
// sequencer. s_axis_tready is high only while the sequencer is idle.
// The budget register is written over its own valid/ready channel, always
// ready, and must only be written while the block is idle. No clearing pass
// is needed after reset: the queue RAM is only read below the fill count.
module budgeted_priority_upload_scheduler #(
    parameter int QUEUE_DEPTH      = bpus_pkg::QUEUE_DEPTH_DEF,
    parameter int FRAMES_IN_FLIGHT = bpus_pkg::FRAMES_IN_FLIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: priority_req[15:0], size_bytes[47:16], upload_tag[63:48],
    //        frame_slot[71:64]
    input  logic [bpus_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]                     s_axis_tuser,
    // master stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: granted_tag[15:0], granted_slot[23:16], staging_offset[55:24],
    //        pending_left[61:56], zero[63:62]
    output logic [bpus_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: status[2:0]
    output logic [2:0]                     m_axis_tuser,
    output logic                           m_axis_tlast,
    // budget register write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [31:0]                    i_cfg_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = (FRAMES_IN_FLIGHT > 1) ? $clog2(FRAMES_IN_FLIGHT) : 1;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    bpus_pkg::t_state  r_state, n_state;
    logic [31:0]       r_budget;
    logic [15:0]       r_prio, n_prio;
    logic [31:0]       r_size, n_size;
    logic [15:0]       r_tag, n_tag;
    logic [7:0]        r_slot, n_slot;
    logic [31:0]       r_frame_used, n_frame_used;
    logic [31:0]       r_slot_fill [FRAMES_IN_FLIGHT];
    logic [31:0]       n_slot_fill [FRAMES_IN_FLIGHT];
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;       // insert position / scan read index
    logic [CW-1:0]     r_widx, n_widx;     // scan compaction write index
    logic [CW-1:0]     r_total, n_total;
    logic [CW-1:0]     r_ngrant, n_ngrant;
    logic [31:0]       r_frame_sum, n_frame_sum;
    bpus_pkg::t_entry  r_ent, n_ent;
    logic              r_held_valid, n_held_valid;
    bpus_pkg::t_result r_held, n_held;     // newest grant, waits to learn tlast
    bpus_pkg::t_result r_res, n_res;       // single closing result
    bpus_pkg::t_result r_out;
    logic              r_out_valid;

    // ---------------------------------------------------------------
    // Queue RAM
    // ---------------------------------------------------------------
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    bpus_pkg::t_entry ram_wdata, ram_rdata;

    bpus_ram #(
        .WIDTH ($bits(bpus_pkg::t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Shared add/compare unit: a + b <= budget, exact 33-bit sum
    // ---------------------------------------------------------------
    logic [31:0] unit_a, unit_b;
    logic [32:0] unit_sum;
    logic        unit_fits;

    assign unit_sum  = {1'b0, unit_a} + {1'b0, unit_b};
    assign unit_fits = unit_sum <= {1'b0, r_budget};

    // ---------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------
    function automatic bpus_pkg::t_result mk_result(bpus_pkg::t_status st,
                                                    logic [CW-1:0] pend);
        bpus_pkg::t_result res;
        res         = '0;
        res.status  = st;
        res.pending = 6'(pend);
        res.last    = 1'b1;
        return res;
    endfunction

    logic [15:0]       in_prio;
    logic [31:0]       in_size;
    logic [15:0]       in_tag;
    logic [7:0]        in_slot;
    logic              in_slot_ok;
    logic [SW-1:0]     sidx;
    logic [CW-1:0]     idx_m1;
    logic              out_free;
    logic              load_out;
    bpus_pkg::t_result out_data;
    bpus_pkg::t_entry  new_ent;
    logic              grant_go;

    assign in_prio    = s_axis_tdata[15:0];
    assign in_size    = s_axis_tdata[47:16];
    assign in_tag     = s_axis_tdata[63:48];
    assign in_slot    = s_axis_tdata[71:64];
    assign in_slot_ok = in_slot < 8'(FRAMES_IN_FLIGHT);
    assign sidx       = r_slot[SW-1:0];
    assign idx_m1     = r_idx - 1'b1;
    assign out_free   = !r_out_valid || m_axis_tready;
    assign new_ent    = '{tag: r_tag, size: r_size, prio: r_prio};

    assign s_axis_tready = (r_state == bpus_pkg::S_IDLE);
    assign o_cfg_ready   = 1'b1;

    // ---------------------------------------------------------------
    // Sequencer: next state and datapath control
    // ---------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_prio       = r_prio;
        n_size       = r_size;
        n_tag        = r_tag;
        n_slot       = r_slot;
        n_frame_used = r_frame_used;
        n_slot_fill  = r_slot_fill;
        n_count      = r_count;
        n_idx        = r_idx;
        n_widx       = r_widx;
        n_total      = r_total;
        n_ngrant     = r_ngrant;
        n_frame_sum  = r_frame_sum;
        n_ent        = r_ent;
        n_held_valid = r_held_valid;
        n_held       = r_held;
        n_res        = r_res;
        ram_we       = 1'b0;
        ram_waddr    = r_widx[AW-1:0];
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = r_idx[AW-1:0];
        unit_a       = r_frame_used;
        unit_b       = ram_rdata.size;
        load_out     = 1'b0;
        out_data     = r_res;
        grant_go     = 1'b0;

        unique case (r_state)
            bpus_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_prio = in_prio;
                    n_size = in_size;
                    n_tag  = in_tag;
                    n_slot = in_slot;
                    unique case (s_axis_tuser)
                        bpus_pkg::KIND_SUBMIT: begin
                            if (in_size == '0) begin
                                n_res   = mk_result(bpus_pkg::ST_IGNORED, r_count);
                                n_state = bpus_pkg::S_RESULT;
                            end else if (r_count >= CW'(QUEUE_DEPTH)) begin
                                n_res   = mk_result(bpus_pkg::ST_FULL, r_count);
                                n_state = bpus_pkg::S_RESULT;
                            end else begin
                                n_idx   = r_count;
                                n_state = bpus_pkg::S_INS_RD;
                            end
                        end
                        bpus_pkg::KIND_BEGIN: begin
                            n_frame_used = '0;
                            if (in_slot_ok) begin
                                n_slot_fill[in_slot[SW-1:0]] = '0;
                            end
                            n_res   = mk_result(bpus_pkg::ST_BEGUN, r_count);
                            n_state = bpus_pkg::S_RESULT;
                        end
                        bpus_pkg::KIND_PROCESS: begin
                            // bad slot grants nothing and keeps the queue
                            if (r_count == '0 || !in_slot_ok) begin
                                n_res   = mk_result(bpus_pkg::ST_NONE, r_count);
                                n_state = bpus_pkg::S_RESULT;
                            end else begin
                                n_idx        = '0;
                                n_widx       = '0;
                                n_total      = r_count;
                                n_ngrant     = '0;
                                n_held_valid = 1'b0;
                                n_state      = bpus_pkg::S_SCAN_RD;
                            end
                        end
                        default: begin
                            // undefined kind: no effect, no result
                        end
                    endcase
                end
            end

            // insertion: shift larger-priority entries up one place
            bpus_pkg::S_INS_RD: begin
                if (r_idx == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[AW-1:0];
                    ram_wdata = new_ent;
                    n_count   = r_count + 1'b1;
                    n_res     = mk_result(bpus_pkg::ST_QUEUED, r_count + 1'b1);
                    n_state   = bpus_pkg::S_RESULT;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_m1[AW-1:0];
                    n_state   = bpus_pkg::S_INS_CMP;
                end
            end

            bpus_pkg::S_INS_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
                if ($signed(ram_rdata.prio) > $signed(r_prio)) begin
                    ram_wdata = ram_rdata;
                    n_idx     = idx_m1;
                    n_state   = bpus_pkg::S_INS_RD;
                end else begin
                    ram_wdata = new_ent;
                    n_count   = r_count + 1'b1;
                    n_res     = mk_result(bpus_pkg::ST_QUEUED, r_count + 1'b1);
                    n_state   = bpus_pkg::S_RESULT;
                end
            end

            // scan: read next entry or close out the process beat
            bpus_pkg::S_SCAN_RD: begin
                if (r_idx == r_total) begin
                    n_count = r_widx;
                    if (r_held_valid) begin
                        n_res      = r_held;
                        n_res.last = 1'b1;
                    end else begin
                        n_res = mk_result(bpus_pkg::ST_NONE, r_widx);
                    end
                    n_held_valid = 1'b0;
                    n_state      = bpus_pkg::S_RESULT;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx[AW-1:0];
                    n_state   = bpus_pkg::S_FIT_FRAME;
                end
            end

            // frame budget check
            bpus_pkg::S_FIT_FRAME: begin
                n_ent  = ram_rdata;
                unit_a = r_frame_used;
                unit_b = ram_rdata.size;
                if (unit_fits) begin
                    n_frame_sum = unit_sum[31:0];
                    n_state     = bpus_pkg::S_FIT_SLOT;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_widx[AW-1:0];
                    ram_wdata = ram_rdata;
                    n_widx    = r_widx + 1'b1;
                    n_idx     = r_idx + 1'b1;
                    n_state   = bpus_pkg::S_SCAN_RD;
                end
            end

            // slot staging check; a grant pushes out the previous held grant
            bpus_pkg::S_FIT_SLOT: begin
                unit_a = r_slot_fill[sidx];
                unit_b = r_ent.size;
                if (unit_fits) begin
                    if (!r_held_valid || out_free) begin
                        grant_go = 1'b1;
                        if (r_held_valid) begin
                            load_out = 1'b1;
                            out_data = r_held;
                        end
                        n_held         = '0;
                        n_held.status  = bpus_pkg::ST_GRANTED;
                        n_held.tag     = r_ent.tag;
                        n_held.slot    = r_slot;
                        n_held.offset  = r_slot_fill[sidx];
                        n_held.pending = 6'(r_total - r_ngrant - 1'b1);
                        n_held.last    = 1'b0;
                        n_held_valid   = 1'b1;
                        n_slot_fill[sidx] = unit_sum[31:0];
                        n_frame_used   = r_frame_sum;
                        n_ngrant       = r_ngrant + 1'b1;
                        n_idx          = r_idx + 1'b1;
                        n_state        = bpus_pkg::S_SCAN_RD;
                    end
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_widx[AW-1:0];
                    ram_wdata = r_ent;
                    n_widx    = r_widx + 1'b1;
                    n_idx     = r_idx + 1'b1;
                    n_state   = bpus_pkg::S_SCAN_RD;
                end
            end

            bpus_pkg::S_RESULT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_data = r_res;
                    n_state  = bpus_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bpus_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bpus_pkg::S_IDLE;
            r_count      <= '0;
            r_frame_used <= '0;
            r_held_valid <= 1'b0;
            for (int f = 0; f < FRAMES_IN_FLIGHT; f++) begin
                r_slot_fill[f] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_frame_used <= n_frame_used;
            r_held_valid <= n_held_valid;
            r_slot_fill  <= n_slot_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio      <= n_prio;
        r_size      <= n_size;
        r_tag       <= n_tag;
        r_slot      <= n_slot;
        r_idx       <= n_idx;
        r_widx      <= n_widx;
        r_total     <= n_total;
        r_ngrant    <= n_ngrant;
        r_frame_sum <= n_frame_sum;
        r_ent       <= n_ent;
        r_held      <= n_held;
        r_res       <= n_res;
    end

    // budget register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= bpus_pkg::BUDGET_RESET;
        end else if (i_cfg_valid) begin
            r_budget <= i_cfg_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.pending, r_out.offset, r_out.slot, r_out.tag};
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out.last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

    a_compact_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpus_pkg::S_SCAN_RD || r_state == bpus_pkg::S_FIT_FRAME ||
         r_state == bpus_pkg::S_FIT_SLOT) |-> (r_widx <= r_idx && r_idx <= r_total))
        else $error("scan write index passed read index");

    a_ins_not_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpus_pkg::S_INS_CMP) |-> (r_idx != '0))
        else $error("insert compare at queue front");

    a_grant_in_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grant_go |=> (r_frame_used <= r_budget && r_slot_fill[sidx] <= r_budget))
        else $error("grant exceeded budget");

    a_held_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("result loaded over an unsent beat");

endmodule
